// File: hw/rtl/leg_forward_kinematics_core_assert.svh
// assertion macros for the leg forward kinematics core
`ifndef LEG_FORWARD_KINEMATICS_CORE_ASSERT_SVH
`define LEG_FORWARD_KINEMATICS_CORE_ASSERT_SVH

// same-cycle implication
`define LFK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LFK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lfk_pkg.sv
// shared constants for the leg forward kinematics core
`timescale 1ns / 1ps

package lfk_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_BODY_RADIUS    = 3'd0;
  localparam logic [2:0] REG_COXA_LEN       = 3'd1;
  localparam logic [2:0] REG_FEMUR_LEN      = 3'd2;
  localparam logic [2:0] REG_TIBIA_LEN      = 3'd3;
  localparam logic [2:0] REG_BASE_ANGLES_LO = 3'd4;
  localparam logic [2:0] REG_BASE_ANGLES_HI = 3'd5;

  // sine evaluation constants
  localparam logic [15:0] QUARTER     = 16'd16384;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;

  // horner denominators, first step first
  localparam int unsigned DEN_0 = 156;
  localparam int unsigned DEN_1 = 110;
  localparam int unsigned DEN_2 = 72;
  localparam int unsigned DEN_3 = 42;
  localparam int unsigned DEN_4 = 20;
  localparam int unsigned DEN_5 = 6;

  // register stages from angle to signed sine
  localparam int unsigned SINE_LAT = 23;

  // output saturation limits
  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

endpackage

// File: hw/rtl/lfk_horner.sv
// one horner step of the sine series: t = 1 - floor(x2*t) / D, three stages
`timescale 1ns / 1ps

module lfk_horner #(
  parameter int unsigned D = 6
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x2_in,
  input  logic [30:0] t_in,
  output logic [31:0] x2_out,
  output logic [30:0] t_out
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / D);
  localparam logic [31:0] DEN   = 32'(D);

  logic [62:0] prod;
  logic [31:0] p1;
  logic [31:0] x2_s1;
  logic [63:0] qprod;
  logic [31:0] p2;
  logic [31:0] q0;
  logic [31:0] x2_s2;
  logic [31:0] rem;
  logic [31:0] q;

  // product of x squared and t, scaled back to q30
  assign prod = 63'(x2_in) * 63'(t_in);

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= prod[61:30];
      x2_s1 <= x2_in;
    end
  end

  // reciprocal estimate of the quotient, low by at most one
  assign qprod = 64'(p1) * 64'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      p2    <= p1;
      q0    <= qprod[63:32];
      x2_s2 <= x2_s1;
    end
  end

  // remainder check and new t
  always_comb begin
    rem = p2 - 32'(q0 * DEN);
    q   = (rem >= DEN) ? q0 + 32'd1 : q0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_out  <= 31'(lfk_pkg::Q30_ONE - q);
      x2_out <= x2_s2;
    end
  end

endmodule

// File: hw/rtl/lfk_sine.sv
// pipelined sine of a 16-bit binary angle, TRIG_BITS fraction bits
`timescale 1ns / 1ps

module lfk_sine #(
  parameter int unsigned TRIG_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [15:0]                 angle,
  output logic signed [TRIG_BITS+1:0] value
);

  localparam int unsigned SH = 30 - TRIG_BITS;
  localparam logic [31:0] HALF = 32'd1 << (29 - TRIG_BITS);
  localparam int unsigned HSTAGES = 18;

  logic [14:0] arg0;
  logic        neg0;
  logic [45:0] xprod;
  logic [30:0] x1;
  logic        neg1;
  logic [61:0] sq;
  logic [31:0] x2_s2;
  logic [30:0] x_s2;
  logic        neg2;
  logic [30:0] xs [0:HSTAGES-1];
  logic        negs [0:HSTAGES-1];
  logic [31:0] x2c [0:6];
  logic [30:0] tc [0:6];
  logic [61:0] sprod;
  logic [31:0] s21;
  logic        neg21;
  logic [31:0] sc;
  logic [31:0] ssum;
  logic [TRIG_BITS:0] rnd;
  logic signed [TRIG_BITS+1:0] mag_s;

  // quadrant fold to a quarter-wave argument
  always_ff @(posedge clk) begin
    if (en) begin
      arg0 <= angle[14] ? 15'(lfk_pkg::QUARTER - {2'b00, angle[13:0]}) : {1'b0, angle[13:0]};
      neg0 <= angle[15];
    end
  end

  // scale to radians in q30
  assign xprod = 46'(arg0) * 46'(lfk_pkg::HALF_PI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= xprod[44:14];
      neg1 <= neg0;
    end
  end

  // x squared
  assign sq = 62'(x1) * 62'(x1);

  always_ff @(posedge clk) begin
    if (en) begin
      x2_s2 <= sq[61:30];
      x_s2  <= x1;
      neg2  <= neg1;
    end
  end

  // horner chain
  assign x2c[0] = x2_s2;
  assign tc[0]  = 31'(lfk_pkg::Q30_ONE);

  lfk_horner #(.D(lfk_pkg::DEN_0)) u_h0 (.clk(clk), .en(en), .x2_in(x2c[0]), .t_in(tc[0]),
                                         .x2_out(x2c[1]), .t_out(tc[1]));
  lfk_horner #(.D(lfk_pkg::DEN_1)) u_h1 (.clk(clk), .en(en), .x2_in(x2c[1]), .t_in(tc[1]),
                                         .x2_out(x2c[2]), .t_out(tc[2]));
  lfk_horner #(.D(lfk_pkg::DEN_2)) u_h2 (.clk(clk), .en(en), .x2_in(x2c[2]), .t_in(tc[2]),
                                         .x2_out(x2c[3]), .t_out(tc[3]));
  lfk_horner #(.D(lfk_pkg::DEN_3)) u_h3 (.clk(clk), .en(en), .x2_in(x2c[3]), .t_in(tc[3]),
                                         .x2_out(x2c[4]), .t_out(tc[4]));
  lfk_horner #(.D(lfk_pkg::DEN_4)) u_h4 (.clk(clk), .en(en), .x2_in(x2c[4]), .t_in(tc[4]),
                                         .x2_out(x2c[5]), .t_out(tc[5]));
  lfk_horner #(.D(lfk_pkg::DEN_5)) u_h5 (.clk(clk), .en(en), .x2_in(x2c[5]), .t_in(tc[5]),
                                         .x2_out(x2c[6]), .t_out(tc[6]));

  // x and sign ride alongside the horner chain
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]   <= x_s2;
      negs[0] <= neg2;
      for (int k = 1; k < HSTAGES; k++) begin
        xs[k]   <= xs[k-1];
        negs[k] <= negs[k-1];
      end
    end
  end

  // final multiply by x
  assign sprod = 62'(xs[HSTAGES-1]) * 62'(tc[6]);

  always_ff @(posedge clk) begin
    if (en) begin
      s21   <= sprod[61:30];
      neg21 <= negs[HSTAGES-1];
    end
  end

  // clamp to one, round to trig precision, apply sign
  always_comb begin
    sc    = (s21 > lfk_pkg::Q30_ONE) ? lfk_pkg::Q30_ONE : s21;
    ssum  = sc + HALF;
    rnd   = ssum[30:SH];
    mag_s = $signed({1'b0, rnd});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= neg21 ? -mag_s : mag_s;
    end
  end

endmodule

// File: hw/rtl/leg_forward_kinematics_core.sv
// Leg forward kinematics core: foot position of one leg from its three joint angles.
// One pose enters per clock while the output is not stalled. Each pose passes through
// the sine pipelines (23 stages, mostly the six three-stage horner steps) plus the
// input register and six multiply, sum and rounding stages. A stall on the output freezes
// the whole pipeline, so in_stall follows out_stall while a result is waiting. The
// configuration registers are read directly by the pipeline and must only be written
// while no pose is in flight. Leg numbers at or above NUM_LEGS give bad_leg with zeros.
`timescale 1ns / 1ps

module leg_forward_kinematics_core #(
  parameter int unsigned NUM_LEGS  = 6,
  parameter int unsigned TRIG_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // pose input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         leg_number,
  input  logic signed [15:0] coxa_angle,
  input  logic signed [15:0] femur_angle,
  input  logic signed [15:0] tibia_angle,
  // foot position output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [18:0] foot_x,
  output logic signed [18:0] foot_y,
  output logic signed [18:0] foot_z,
  output logic               bad_leg,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  `include "leg_forward_kinematics_core_assert.svh"

  localparam int unsigned W   = TRIG_BITS + 2;
  localparam int unsigned PW  = W + 17;
  localparam int unsigned MW  = W + 19;
  localparam int unsigned XW  = TRIG_BITS + 23;
  localparam int unsigned LAT = lfk_pkg::SINE_LAT + 7;
  localparam int unsigned NT  = 8;

  // sine unit slots
  localparam int unsigned SIN_F = 0;
  localparam int unsigned COS_F = 1;
  localparam int unsigned SIN_T = 2;
  localparam int unsigned COS_T = 3;
  localparam int unsigned SIN_B = 4;
  localparam int unsigned COS_B = 5;
  localparam int unsigned SIN_P = 6;
  localparam int unsigned COS_P = 7;

  localparam logic [XW-1:0]        HALF   = XW'(1) << (TRIG_BITS - 1);
  localparam logic signed [XW-1:0] SAT_HI = XW'(lfk_pkg::OUT_MAX);
  localparam logic signed [XW-1:0] SAT_LO = XW'(lfk_pkg::OUT_MIN);

  logic [15:0]  body_radius;
  logic [15:0]  coxa_len;
  logic [15:0]  femur_len;
  logic [15:0]  tibia_len;
  logic [63:0]  base_angles_lo;
  logic [63:0]  base_angles_hi;

  logic         en;
  logic [LAT-1:0] vld;
  logic         bad_d [0:LAT-2];
  logic [127:0] base_all;
  logic [15:0]  base_sel;
  logic [15:0]  phi;
  logic [15:0]  ft;
  logic [15:0]  ang_next [0:NT-1];
  logic [15:0]  ang [0:NT-1];
  logic signed [W-1:0] trig [0:NT-1];

  logic signed [PW-1:0] pfc, pts, pfs, ptc, pbc1, pbs1;
  logic signed [W-1:0]  cphi1, sphi1, cphi2, sphi2, cphi3, sphi3;
  logic signed [XW-1:0] rq, zq;
  logic signed [PW-1:0] pbc2, pbs2, pbc3, pbs3, pbc4, pbs4;
  logic signed [18:0]   r3, z3, z4, z5;
  logic signed [MW-1:0] xm4, ym4;
  logic signed [XW-1:0] xq5, yq5;

  // divide by 2^TRIG_BITS, rounding half away from zero
  function automatic logic signed [XW-1:0] round_trig(input logic signed [XW-1:0] v);
    logic [XW-1:0] mag;
    logic [XW-1:0] q;
    mag = v[XW-1] ? XW'(-v) : XW'(v);
    q   = (mag + HALF) >> TRIG_BITS;
    return v[XW-1] ? -$signed(q) : $signed(q);
  endfunction

  // clamp to the output range
  function automatic logic signed [18:0] sat_out(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] c;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = v;
    end
    return 19'(c);
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_radius    <= '0;
      coxa_len       <= '0;
      femur_len      <= '0;
      tibia_len      <= '0;
      base_angles_lo <= '0;
      base_angles_hi <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lfk_pkg::REG_BODY_RADIUS:    body_radius    <= cfg_data[15:0];
        lfk_pkg::REG_COXA_LEN:       coxa_len       <= cfg_data[15:0];
        lfk_pkg::REG_FEMUR_LEN:      femur_len      <= cfg_data[15:0];
        lfk_pkg::REG_TIBIA_LEN:      tibia_len      <= cfg_data[15:0];
        lfk_pkg::REG_BASE_ANGLES_LO: base_angles_lo <= cfg_data;
        lfk_pkg::REG_BASE_ANGLES_HI: base_angles_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: everything holds while a result waits
  assign en        = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // bad leg flag travels with the beat
  always_ff @(posedge clk) begin
    if (en) begin
      bad_d[0] <= ({1'b0, leg_number} >= 4'(NUM_LEGS));
      for (int k = 1; k < LAT - 1; k++) begin
        bad_d[k] <= bad_d[k-1];
      end
    end
  end

  // base angle lookup and joint angle sums
  always_comb begin
    base_all         = {base_angles_hi, base_angles_lo};
    base_sel         = base_all[{leg_number, 4'b0000} +: 16];
    phi              = base_sel + coxa_angle;
    ft               = femur_angle + tibia_angle;
    ang_next[SIN_F]  = femur_angle;
    ang_next[COS_F]  = femur_angle + lfk_pkg::QUARTER;
    ang_next[SIN_T]  = ft;
    ang_next[COS_T]  = ft + lfk_pkg::QUARTER;
    ang_next[SIN_B]  = base_sel;
    ang_next[COS_B]  = base_sel + lfk_pkg::QUARTER;
    ang_next[SIN_P]  = phi;
    ang_next[COS_P]  = phi + lfk_pkg::QUARTER;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NT; k++) begin
        ang[k] <= ang_next[k];
      end
    end
  end

  // eight sine pipelines
  for (genvar g = 0; g < NT; g++) begin : g_trig
    lfk_sine #(.TRIG_BITS(TRIG_BITS)) u_sine (
      .clk   (clk),
      .en    (en),
      .angle (ang[g]),
      .value (trig[g])
    );
  end

  // length products
  always_ff @(posedge clk) begin
    if (en) begin
      pfc   <= PW'($signed({1'b0, femur_len})) * PW'(trig[COS_F]);
      pts   <= PW'($signed({1'b0, tibia_len})) * PW'(trig[SIN_T]);
      pfs   <= PW'($signed({1'b0, femur_len})) * PW'(trig[SIN_F]);
      ptc   <= PW'($signed({1'b0, tibia_len})) * PW'(trig[COS_T]);
      pbc1  <= PW'($signed({1'b0, body_radius})) * PW'(trig[COS_B]);
      pbs1  <= PW'($signed({1'b0, body_radius})) * PW'(trig[SIN_B]);
      cphi1 <= trig[COS_P];
      sphi1 <= trig[SIN_P];
    end
  end

  // radial reach and height sums
  always_ff @(posedge clk) begin
    if (en) begin
      rq    <= $signed({7'b0, coxa_len, {TRIG_BITS{1'b0}}}) + XW'(pfc) - XW'(pts);
      zq    <= -XW'(pfs) - XW'(ptc);
      pbc2  <= pbc1;
      pbs2  <= pbs1;
      cphi2 <= cphi1;
      sphi2 <= sphi1;
    end
  end

  // round reach to whole units, finish height
  always_ff @(posedge clk) begin
    if (en) begin
      r3    <= 19'(round_trig(rq));
      z3    <= sat_out(round_trig(zq));
      pbc3  <= pbc2;
      pbs3  <= pbs2;
      cphi3 <= cphi2;
      sphi3 <= sphi2;
    end
  end

  // reach projected onto the leg heading
  always_ff @(posedge clk) begin
    if (en) begin
      xm4  <= MW'(r3) * MW'(cphi3);
      ym4  <= MW'(r3) * MW'(sphi3);
      pbc4 <= pbc3;
      pbs4 <= pbs3;
      z4   <= z3;
    end
  end

  // add the leg base offset
  always_ff @(posedge clk) begin
    if (en) begin
      xq5 <= XW'(pbc4) + XW'(xm4);
      yq5 <= XW'(pbs4) + XW'(ym4);
      z5  <= z4;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      bad_leg <= bad_d[LAT-2];
      foot_x  <= bad_d[LAT-2] ? '0 : sat_out(round_trig(xq5));
      foot_y  <= bad_d[LAT-2] ? '0 : sat_out(round_trig(yq5));
      foot_z  <= bad_d[LAT-2] ? '0 : z5;
    end
  end

  // checks
  `LFK_ASSERT_NOW(a_bad_zero, clk, rst, out_valid && bad_leg, foot_x == 0 && foot_y == 0 && foot_z == 0, "bad leg result not zero")
  `LFK_ASSERT_NOW(a_stall_src, clk, rst, in_stall, out_valid && out_stall, "input stalled without a held result")
  `LFK_ASSERT_NEXT(a_accept_enters, clk, rst, in_valid && !in_stall, vld[0], "accepted beat lost at entry")

endmodule

// File: tb/sv/tb_top.sv
// testbench for the leg forward kinematics core: directed and random poses against a predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LEGS  = 6;
  localparam int unsigned TBITS = 16;
  localparam int unsigned DRAIN = 40;

  // expected foot position of one pose
  typedef struct packed {
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic signed [18:0] z;
    logic               bad;
  } foot_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         leg_number = '0;
  logic signed [15:0] coxa_angle = '0;
  logic signed [15:0] femur_angle = '0;
  logic signed [15:0] tibia_angle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [18:0] foot_x;
  logic signed [18:0] foot_y;
  logic signed [18:0] foot_z;
  logic               bad_leg;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  leg_forward_kinematics_core #(.NUM_LEGS(LEGS), .TRIG_BITS(TBITS)) uut (.*);

  // predictor copy of the configuration registers
  logic [15:0] m_radius, m_coxa, m_femur, m_tibia;
  logic [63:0] m_base_lo, m_base_hi;

  function automatic longint quarter_sine(input longint unsigned a);
    longint unsigned x, x2, t, s;
    int unsigned den[6];
    den = '{lfk_pkg::DEN_0, lfk_pkg::DEN_1, lfk_pkg::DEN_2,
            lfk_pkg::DEN_3, lfk_pkg::DEN_4, lfk_pkg::DEN_5};
    x  = (a * 64'd1686629713) >> 14;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    for (int i = 0; i < 6; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / den[i];
    s = (x * t) >> 30;
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    s = (s + (64'd1 << (29 - TBITS))) >> (30 - TBITS);
    return longint'(s);
  endfunction

  function automatic longint ang_sin(input logic [15:0] a);
    logic [13:0] r;
    longint v;
    r = a[13:0];
    v = a[14] ? quarter_sine(64'd16384 - r) : quarter_sine(r);
    return a[15] ? -v : v;
  endfunction

  function automatic longint ang_cos(input logic [15:0] a);
    return ang_sin(a + 16'd16384);
  endfunction

  function automatic longint round_frac(input longint v);
    longint half;
    half = 64'sd1 <<< (TBITS - 1);
    if (v >= 0) return (v + half) >>> TBITS;
    return -((-v + half) >>> TBITS);
  endfunction

  function automatic logic signed [18:0] clamp(input longint v);
    if (v > lfk_pkg::OUT_MAX) return 19'(lfk_pkg::OUT_MAX);
    if (v < lfk_pkg::OUT_MIN) return 19'(lfk_pkg::OUT_MIN);
    return 19'(v);
  endfunction

  function automatic foot_t foot_of(input logic [2:0] leg, input logic [15:0] ca,
                                    input logic [15:0] fa, input logic [15:0] ta);
    foot_t f;
    logic [15:0] base, phi, ft;
    longint r;
    f = '0;
    if (leg >= LEGS) begin
      f.bad = 1'b1;
      return f;
    end
    base = (leg < 4) ? m_base_lo[16*leg +: 16] : m_base_hi[16*(leg-4) +: 16];
    phi = base + ca;
    ft = fa + ta;
    r = round_frac((longint'(m_coxa) <<< TBITS) + longint'(m_femur) * ang_cos(fa)
                   - longint'(m_tibia) * ang_sin(ft));
    f.x = clamp(round_frac(longint'(m_radius) * ang_cos(base) + r * ang_cos(phi)));
    f.y = clamp(round_frac(longint'(m_radius) * ang_sin(base) + r * ang_sin(phi)));
    f.z = clamp(round_frac(-longint'(m_femur) * ang_sin(fa) - longint'(m_tibia) * ang_cos(ft)));
    return f;
  endfunction

  // queue of expected feet, oldest first
  class foot_board;
    foot_t pending[$];
    int    errors = 0;

    function void note_pose(foot_t f);
      pending.push_back(f);
    endfunction

    function void check_foot(foot_t got);
      foot_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected x=%0d y=%0d z=%0d bad=%0b, got x=%0d y=%0d z=%0d bad=%0b",
                   want.x, want.y, want.z, want.bad, got.x, got.y, got.z, got.bad);
      end
    endfunction
  endclass

  foot_board board = new();

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #50ms;
    $display("[leg_forward_kinematics_core] ERROR");
    $finish;
  end

  // result side: sample at rising edge, random stall at falling edge
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_foot({foot_x, foot_y, foot_z, bad_leg});
      @(negedge clk);
      if (!rst && out_valid && !out_stall) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // one register write; valid stays up for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lfk_pkg::REG_BODY_RADIUS:    m_radius  = val[15:0];
      lfk_pkg::REG_COXA_LEN:       m_coxa    = val[15:0];
      lfk_pkg::REG_FEMUR_LEN:      m_femur   = val[15:0];
      lfk_pkg::REG_TIBIA_LEN:      m_tibia   = val[15:0];
      lfk_pkg::REG_BASE_ANGLES_LO: m_base_lo = val;
      lfk_pkg::REG_BASE_ANGLES_HI: m_base_hi = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_lengths(input logic [15:0] rad, input logic [15:0] cx,
                              input logic [15:0] fm, input logic [15:0] tb,
                              input logic [63:0] lo, input logic [63:0] hi);
    write_reg(lfk_pkg::REG_BODY_RADIUS, {48'h0, rad});
    write_reg(lfk_pkg::REG_COXA_LEN, {48'h0, cx});
    write_reg(lfk_pkg::REG_FEMUR_LEN, {48'h0, fm});
    write_reg(lfk_pkg::REG_TIBIA_LEN, {48'h0, tb});
    write_reg(lfk_pkg::REG_BASE_ANGLES_LO, lo);
    write_reg(lfk_pkg::REG_BASE_ANGLES_HI, hi);
    cfg_valid <= 1'b0;
  endtask

  // send one pose beat; valid held across back-to-back beats
  task automatic send_pose(input logic [2:0] leg, input logic [15:0] ca,
                           input logic [15:0] fa, input logic [15:0] ta, input bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    leg_number  <= leg;
    coxa_angle  <= ca;
    femur_angle <= fa;
    tibia_angle <= ta;
    do @(posedge clk); while (in_stall);
    board.note_pose(foot_of(leg, ca, fa, ta));
    @(negedge clk);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(16384 * $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [15:0] edges[6];
    edges = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'h7fff, 16'hffff};
    m_radius = '0; m_coxa = '0; m_femur = '0; m_tibia = '0; m_base_lo = '0; m_base_hi = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero registers, then moderate, then extreme lengths for saturation
    send_pose(3'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    drain_all();
    load_lengths(16'd800, 16'd600, 16'd1200, 16'd1500,
                 64'hc000_8000_4000_0000, 64'h1234_ffff_aaaa_2aaa);
    for (int i = 0; i < 8; i++) send_pose(3'(i), edges[i % 6], edges[(i + 2) % 6],
                                          edges[(i + 4) % 6], 1'b0);
    drain_all();
    load_lengths(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < 12; i++) send_pose(3'(i % 8), edges[i % 6], edges[(i * 5) % 6],
                                           edges[(i + 1) % 6], 1'b0);
    send_pose(3'd7, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
    drain_all();

    // random phases with changing registers
    for (int ph = 0; ph < 8; ph++) begin
      load_lengths(16'($urandom), (ph == 1) ? 16'h0 : 16'($urandom_range(0, 4000)),
                   16'($urandom), (ph == 2) ? 16'h0 : 16'($urandom),
                   {$urandom, $urandom}, {$urandom, $urandom});
      for (int n = 0; n < 125; n++)
        send_pose(3'($urandom), pick_angle(), pick_angle(), pick_angle(),
                  (ph % 3 != 0) && $urandom_range(0, 1));
      drain_all();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[leg_forward_kinematics_core] OK");
    end else begin
      $display("[leg_forward_kinematics_core] ERROR");
    end
    $finish;
  end
endmodule
